[src/tfsl_pkg.sv]
`timescale 1ns / 1ps
package tfsl_pkg;

  localparam int COORD_BITS      = 16;
  localparam int LIGHT_FRAC_BITS = 15;

  localparam int DIFF_W = COORD_BITS + 1;
  localparam int PROD_W = 2 * DIFF_W;
  localparam int NRM_W  = PROD_W + 1;
  localparam int MAG_W  = PROD_W;
  localparam int HALF_W = (MAG_W + 1) / 2;
  localparam int PP_W   = 2 * HALF_W;
  localparam int SQ_W   = 2 * MAG_W;
  localparam int SUM_W  = SQ_W + 2;
  localparam int Q_W    = LIGHT_FRAC_BITS + 1;
  localparam int POS_W  = $clog2(Q_W);
  localparam int SH_W   = $clog2(2 * Q_W + 2);
  localparam int T_SH   = 2 * LIGHT_FRAC_BITS + 2;
  localparam int ACC_W  = SUM_W + 2 * LIGHT_FRAC_BITS + 6;
  localparam int FRONT_STAGES = 6;

  typedef logic signed [ACC_W-1:0] acc_t;

  typedef struct packed {
    logic             valid;
    logic             deg;
    logic             neg;
    logic [SUM_W-1:0] s;
    acc_t             r;
    acc_t             p;
    logic [Q_W-1:0]   q;
  } tfsl_beat_t;

endpackage

[src/tfsl_front.sv]
`timescale 1ns / 1ps
module tfsl_front (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      adv,
  input  logic                                      in_valid,
  input  logic signed [tfsl_pkg::COORD_BITS-1:0]    ax,
  input  logic signed [tfsl_pkg::COORD_BITS-1:0]    ay,
  input  logic signed [tfsl_pkg::COORD_BITS-1:0]    az,
  input  logic signed [tfsl_pkg::COORD_BITS-1:0]    bx,
  input  logic signed [tfsl_pkg::COORD_BITS-1:0]    by_coord,
  input  logic signed [tfsl_pkg::COORD_BITS-1:0]    bz,
  input  logic signed [tfsl_pkg::COORD_BITS-1:0]    cx,
  input  logic signed [tfsl_pkg::COORD_BITS-1:0]    cy,
  input  logic signed [tfsl_pkg::COORD_BITS-1:0]    cz,
  output tfsl_pkg::tfsl_beat_t                      beat
);

  localparam int CB = tfsl_pkg::COORD_BITS;

  logic [tfsl_pkg::FRONT_STAGES-1:0]             vld;
  logic signed [tfsl_pkg::DIFF_W-1:0]            u [3];
  logic signed [tfsl_pkg::DIFF_W-1:0]            v [3];
  logic signed [tfsl_pkg::PROD_W-1:0]            pr [6];
  logic signed [tfsl_pkg::NRM_W-1:0]             nrm [3];
  logic [tfsl_pkg::MAG_W-1:0]                    mag [3];
  logic [2:0]                                    neg_d;
  logic [tfsl_pkg::PP_W-1:0]                     hh [3];
  logic [tfsl_pkg::PP_W-1:0]                     hl [3];
  logic [tfsl_pkg::PP_W-1:0]                     ll [3];
  logic [tfsl_pkg::SQ_W-1:0]                     sq [3];
  logic [tfsl_pkg::PP_W-1:0]                     mag_ext [3];
  logic [tfsl_pkg::SUM_W-1:0]                    s_sum;
  tfsl_pkg::acc_t                                s_acc;
  tfsl_pkg::acc_t                                t_acc;
  logic                                          out_deg;
  logic                                          out_neg;
  logic [tfsl_pkg::SUM_W-1:0]                    out_s;
  tfsl_pkg::acc_t                                out_r;
  tfsl_pkg::acc_t                                out_p;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[tfsl_pkg::FRONT_STAGES-2:0], in_valid};
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_ext[i] = tfsl_pkg::PP_W'(mag[i]);
    end
    nrm[0] = tfsl_pkg::NRM_W'(pr[0]) - tfsl_pkg::NRM_W'(pr[1]);
    nrm[1] = tfsl_pkg::NRM_W'(pr[2]) - tfsl_pkg::NRM_W'(pr[3]);
    nrm[2] = tfsl_pkg::NRM_W'(pr[4]) - tfsl_pkg::NRM_W'(pr[5]);
    s_sum = tfsl_pkg::SUM_W'(sq[0]) + tfsl_pkg::SUM_W'(sq[1]) + tfsl_pkg::SUM_W'(sq[2]);
    s_acc = tfsl_pkg::acc_t'({{(tfsl_pkg::ACC_W-tfsl_pkg::SUM_W){1'b0}}, s_sum});
    t_acc = tfsl_pkg::acc_t'({{(tfsl_pkg::ACC_W-tfsl_pkg::SQ_W){1'b0}}, sq[2]})
            <<< tfsl_pkg::T_SH;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      u[0] <= {bx[CB-1], bx} - {ax[CB-1], ax};
      u[1] <= {by_coord[CB-1], by_coord} - {ay[CB-1], ay};
      u[2] <= {bz[CB-1], bz} - {az[CB-1], az};
      v[0] <= {cx[CB-1], cx} - {ax[CB-1], ax};
      v[1] <= {cy[CB-1], cy} - {ay[CB-1], ay};
      v[2] <= {cz[CB-1], cz} - {az[CB-1], az};

      pr[0] <= u[1] * v[2];
      pr[1] <= u[2] * v[1];
      pr[2] <= u[2] * v[0];
      pr[3] <= u[0] * v[2];
      pr[4] <= u[0] * v[1];
      pr[5] <= u[1] * v[0];

      for (int i = 0; i < 3; i++) begin
        mag[i] <= nrm[i][tfsl_pkg::NRM_W-1] ? tfsl_pkg::MAG_W'(-nrm[i])
                                             : tfsl_pkg::MAG_W'(nrm[i]);
      end
      neg_d[0] <= nrm[2][tfsl_pkg::NRM_W-1];

      for (int i = 0; i < 3; i++) begin
        hh[i] <= mag_ext[i][tfsl_pkg::PP_W-1:tfsl_pkg::HALF_W]
               * mag_ext[i][tfsl_pkg::PP_W-1:tfsl_pkg::HALF_W];
        hl[i] <= mag_ext[i][tfsl_pkg::PP_W-1:tfsl_pkg::HALF_W]
               * mag_ext[i][tfsl_pkg::HALF_W-1:0];
        ll[i] <= mag_ext[i][tfsl_pkg::HALF_W-1:0] * mag_ext[i][tfsl_pkg::HALF_W-1:0];
      end
      neg_d[1] <= neg_d[0];

      for (int i = 0; i < 3; i++) begin
        sq[i] <= (tfsl_pkg::SQ_W'(hh[i]) << (2 * tfsl_pkg::HALF_W))
               + (tfsl_pkg::SQ_W'(hl[i]) << (tfsl_pkg::HALF_W + 1))
               + tfsl_pkg::SQ_W'(ll[i]);
      end
      neg_d[2] <= neg_d[1];

      out_deg <= (s_sum == '0);
      out_neg <= neg_d[2];
      out_s   <= s_sum;
      out_r   <= t_acc - s_acc;
      out_p   <= -s_acc;
    end
  end

  always_comb begin
    beat.valid = vld[tfsl_pkg::FRONT_STAGES-1];
    beat.deg   = out_deg;
    beat.neg   = out_neg;
    beat.s     = out_s;
    beat.r     = out_r;
    beat.p     = out_p;
    beat.q     = '0;
  end

endmodule

[src/tfsl_cell.sv]
`timescale 1ns / 1ps
module tfsl_cell (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        adv,
  input  logic [tfsl_pkg::POS_W-1:0]  bit_pos,
  input  tfsl_pkg::tfsl_beat_t        beat_in,
  output tfsl_pkg::tfsl_beat_t        beat_out
);

  logic [tfsl_pkg::SH_W-1:0] sh1;
  logic [tfsl_pkg::SH_W-1:0] sh2;
  logic [tfsl_pkg::SH_W-1:0] sh3;
  tfsl_pkg::acc_t            s_ext;
  tfsl_pkg::acc_t            d;
  tfsl_pkg::acc_t            r_try;
  tfsl_pkg::tfsl_beat_t      beat_next;

  always_comb begin
    sh1   = tfsl_pkg::SH_W'(bit_pos) + tfsl_pkg::SH_W'(1);
    sh2   = tfsl_pkg::SH_W'(bit_pos) + tfsl_pkg::SH_W'(2);
    sh3   = tfsl_pkg::SH_W'({bit_pos, 1'b0}) + tfsl_pkg::SH_W'(2);
    s_ext = tfsl_pkg::acc_t'({{(tfsl_pkg::ACC_W-tfsl_pkg::SUM_W){1'b0}}, beat_in.s});
    d     = (beat_in.p <<< sh2) + (s_ext <<< sh3);
    r_try = beat_in.r - d;
    beat_next = beat_in;
    if (!r_try[tfsl_pkg::ACC_W-1]) begin
      beat_next.r = r_try;
      beat_next.p = beat_in.p + (s_ext <<< sh1);
      beat_next.q = beat_in.q | (tfsl_pkg::Q_W'(1) << bit_pos);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      beat_out.valid <= 1'b0;
    end else if (adv) begin
      beat_out <= beat_next;
    end
  end

endmodule

[src/triangle_flat_shade_light_top.sv]
`timescale 1ns / 1ps
// Pipeline: 6 front stages, one cell per result bit (16 cells), then one
// output register.
// Throughput: one triangle per cycle; the whole pipe holds while an output
// beat waits for out_ready.
// Reset: synchronous rst clears all stage valid bits; no beat is in flight after.
module triangle_flat_shade_light_top (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [tfsl_pkg::COORD_BITS-1:0] ax,
  input  logic signed [tfsl_pkg::COORD_BITS-1:0] ay,
  input  logic signed [tfsl_pkg::COORD_BITS-1:0] az,
  input  logic signed [tfsl_pkg::COORD_BITS-1:0] bx,
  input  logic signed [tfsl_pkg::COORD_BITS-1:0] by_coord,
  input  logic signed [tfsl_pkg::COORD_BITS-1:0] bz,
  input  logic signed [tfsl_pkg::COORD_BITS-1:0] cx,
  input  logic signed [tfsl_pkg::COORD_BITS-1:0] cy,
  input  logic signed [tfsl_pkg::COORD_BITS-1:0] cz,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [tfsl_pkg::Q_W-1:0]        light_level,
  output logic                                   degenerate
);

  localparam logic [tfsl_pkg::Q_W-1:0] LEVEL_MAX = {1'b0, {(tfsl_pkg::Q_W-1){1'b1}}};

  logic                        adv;
  tfsl_pkg::tfsl_beat_t        chain [tfsl_pkg::Q_W+1];
  logic [tfsl_pkg::Q_W-1:0]    lvl_mag;
  logic [tfsl_pkg::Q_W-1:0]    lvl;

  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  tfsl_front u_front (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_valid (in_valid),
    .ax       (ax),
    .ay       (ay),
    .az       (az),
    .bx       (bx),
    .by_coord (by_coord),
    .bz       (bz),
    .cx       (cx),
    .cy       (cy),
    .cz       (cz),
    .beat     (chain[0])
  );

  for (genvar g = 0; g < tfsl_pkg::Q_W; g++) begin : g_cell
    tfsl_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .adv      (adv),
      .bit_pos  (tfsl_pkg::POS_W'(tfsl_pkg::Q_W - 1 - g)),
      .beat_in  (chain[g]),
      .beat_out (chain[g+1])
    );
  end

  always_comb begin
    lvl_mag = (chain[tfsl_pkg::Q_W].q > LEVEL_MAX) ? LEVEL_MAX : chain[tfsl_pkg::Q_W].q;
    if (chain[tfsl_pkg::Q_W].deg) begin
      lvl = '0;
    end else if (chain[tfsl_pkg::Q_W].neg) begin
      lvl = -lvl_mag;
    end else begin
      lvl = lvl_mag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= chain[tfsl_pkg::Q_W].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      light_level <= lvl;
      degenerate  <= chain[tfsl_pkg::Q_W].deg;
    end
  end

endmodule

[src/tfsl_checker.sv]
`timescale 1ns / 1ps
module tfsl_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic signed [tfsl_pkg::Q_W-1:0] light_level,
  input logic                            degenerate
);

  a_deg_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && degenerate |-> light_level == '0)
    else $error("degenerate beat with nonzero level");

  a_no_min: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> light_level != {1'b1, {(tfsl_pkg::Q_W-1){1'b0}}})
    else $error("level outside saturated range");

  a_ready_follows: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(light_level) && $stable(degenerate))
    else $error("output beat changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("output valid right after reset");

endmodule

bind triangle_flat_shade_light_top tfsl_checker u_tfsl_checker (.*);
